### rtl/core/wdcl_pkg.sv
// ----------------------------------------------------------------------------
// wdcl_pkg: WAV data chunk locator package
// Shared codes, constants and the result word layout.
// ----------------------------------------------------------------------------
package wdcl_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned FieldBytes  = 4;
  localparam int unsigned CountW     = 4;

  // 'data' packed little-endian
  localparam logic [SizeW-1:0] DataTag = {8'h61, 8'h74, 8'h61, 8'h64};

  localparam logic [1:0] PhaseSkip    = 2'd0;
  localparam logic [1:0] PhaseSize    = 2'd1;
  localparam logic [1:0] PhasePayload = 2'd2;
  localparam logic [1:0] PhaseAfter   = 2'd3;

  typedef struct packed {
    logic [1:0]       phase;
    logic [SizeW-1:0] data_size;
    logic [ByteW-1:0] payload_byte;
    logic             last_payload;
  } wdcl_result_t;

endpackage

### rtl/core/wdcl_if.sv
// ----------------------------------------------------------------------------
// wdcl_if: byte and result stream interfaces
// Valid/ready channels for the input bytes and the result words.
// ----------------------------------------------------------------------------
interface wdcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface wdcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [31:0] data_size;
  logic [7:0]  payload_byte;
  logic        last_payload;

  modport source (output valid, output phase, output data_size, output payload_byte,
                  output last_payload, input ready);
  modport sink   (input valid, input phase, input data_size, input payload_byte,
                  input last_payload, output ready);
endinterface

### rtl/core/wav_data_chunk_locator_top.sv
// Output: a result word is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single result register frees as it is
// taken, so a byte is accepted whenever that register is empty or draining.
// Reset: asynchronous, active low; the parse returns to the header state and
// the result register empties.
// ----------------------------------------------------------------------------
// wav_data_chunk_locator_top: WAV data chunk locator
// Walks a RIFF byte stream, reports the 'data' chunk size and passes its
// payload bytes through.
// ----------------------------------------------------------------------------
module wav_data_chunk_locator_top import wdcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  wdcl_in_if.sink           in_i,
  wdcl_out_if.source        out_o
);

  logic         accept;
  logic         out_valid_q;
  wdcl_result_t result;
  wdcl_result_t out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  wdcl_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (accept),
    .data_byte_i     (in_i.data_byte),
    .start_of_file_i (in_i.start_of_file),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.phase        = out_q.phase;
  assign out_o.data_size    = out_q.data_size;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.last_payload = out_q.last_payload;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte produced no result word");

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_payload |-> out_q.phase == PhasePayload)
    else $error("last payload flag outside payload phase");

  a_skip_no_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.phase == PhaseSkip |-> out_q.data_size == '0)
    else $error("size reported before data chunk found");

  a_payload_only_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.phase != PhasePayload |-> out_q.payload_byte == '0)
    else $error("payload byte outside payload phase");
`endif

endmodule

### rtl/core/wdcl_parser.sv
// ----------------------------------------------------------------------------
// wdcl_parser: RIFF chunk walker
// Holds the parse state and forms the result word for the current byte.
// ----------------------------------------------------------------------------
module wdcl_parser import wdcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [ByteW-1:0]     data_byte_i,
  input  logic                 start_of_file_i,
  output wdcl_result_t         result_o
);

  typedef enum logic [2:0] {
    StHeader, StId, StSize, StSkip, StPayload, StDone
  } state_e;

  state_e              state_q, state_d, state_c;
  logic [CountW-1:0]   cnt_q, cnt_d, cnt_c, cnt_inc;
  logic [SizeW-1:0]    id_q, id_d, id_c;
  logic [SizeW-1:0]    size_q, size_d, size_c;
  logic [SizeW-1:0]    remain_q, remain_d, remain_c, remain_dec;
  logic [SizeW-1:0]    found_q, found_d, found_c;

  always_comb begin
    // start mark restarts the parse on this very byte
    if (start_of_file_i) begin
      state_c  = StHeader;
      cnt_c    = '0;
      id_c     = '0;
      size_c   = '0;
      remain_c = '0;
      found_c  = '0;
    end else begin
      state_c  = state_q;
      cnt_c    = cnt_q;
      id_c     = id_q;
      size_c   = size_q;
      remain_c = remain_q;
      found_c  = found_q;
    end

    cnt_inc    = cnt_c + CountW'(1);
    remain_dec = remain_c - SizeW'(1);

    state_d  = state_c;
    cnt_d    = cnt_c;
    id_d     = id_c;
    size_d   = size_c;
    remain_d = remain_c;
    found_d  = found_c;

    result_o = '{phase: PhaseSkip, data_size: '0, payload_byte: '0, last_payload: 1'b0};

    case (state_c)
      StHeader: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= CountW'(HeaderBytes)) begin
          cnt_d   = '0;
          state_d = StId;
        end
      end
      StId: begin
        id_d  = {data_byte_i, id_c[SizeW-1:ByteW]};
        cnt_d = cnt_inc;
        if (cnt_inc >= CountW'(FieldBytes)) begin
          cnt_d   = '0;
          state_d = StSize;
        end
      end
      StSize: begin
        size_d = {data_byte_i, size_c[SizeW-1:ByteW]};
        cnt_d  = cnt_inc;
        if (cnt_inc >= CountW'(FieldBytes)) begin
          cnt_d    = '0;
          remain_d = size_d;
          if (id_c == DataTag) begin
            found_d            = size_d;
            result_o.phase     = PhaseSize;
            result_o.data_size = size_d;
            state_d            = (size_d == '0) ? StDone : StPayload;
          end else begin
            state_d = (size_d == '0) ? StId : StSkip;
          end
        end
      end
      StSkip: begin
        remain_d = remain_dec;
        if (remain_dec == '0) state_d = StId;
      end
      StPayload: begin
        result_o.phase        = PhasePayload;
        result_o.data_size    = found_c;
        result_o.payload_byte = data_byte_i;
        remain_d              = remain_dec;
        if (remain_dec == '0) begin
          result_o.last_payload = 1'b1;
          state_d               = StDone;
        end
      end
      default: begin
        result_o.phase     = PhaseAfter;
        result_o.data_size = found_c;
        state_d            = StDone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StHeader;
      cnt_q    <= '0;
      id_q     <= '0;
      size_q   <= '0;
      remain_q <= '0;
      found_q  <= '0;
    end else if (advance_i) begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      id_q     <= id_d;
      size_q   <= size_d;
      remain_q <= remain_d;
      found_q  <= found_d;
    end
  end

endmodule

### tb/sv/wdcl_walk_checker.sv
// ----------------------------------------------------------------------------
// wdcl_walk_checker: result checker for the WAV data chunk locator
// Watches the byte and result channels, walks the RIFF chunk list itself for
// every accepted byte and compares each result word with the oldest forecast.
// ----------------------------------------------------------------------------
module wdcl_walk_checker import wdcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wdcl_in_if          in_ch,
  wdcl_out_if         out_ch,
  output int unsigned pending_o,
  output int unsigned faults_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    WalkHeader, WalkId, WalkSize, WalkSkip, WalkPayload, WalkDone
  } walk_state_e;

  walk_state_e       walk_st;
  logic [CountW-1:0] field_cnt;
  logic [SizeW-1:0]  id_acc;
  logic [SizeW-1:0]  size_acc;
  logic [SizeW-1:0]  remaining;
  logic [SizeW-1:0]  data_len;

  wdcl_result_t      forecast_q[$];
  wdcl_result_t      want;

  initial begin
    pending_o = 0;
    faults_o  = 0;
  end

  function automatic void clear_walk();
    walk_st   = WalkHeader;
    field_cnt = '0;
    id_acc    = '0;
    size_acc  = '0;
    remaining = '0;
    data_len  = '0;
  endfunction

  // Advance the chunk walk by one byte and give the word it should produce.
  function automatic wdcl_result_t walk_byte(input logic [ByteW-1:0] b, input logic sof);
    wdcl_result_t r;
    r = '0;
    if (sof) clear_walk();
    case (walk_st)
      WalkHeader: begin
        field_cnt++;
        if (field_cnt >= HeaderBytes) begin
          field_cnt = '0;
          walk_st   = WalkId;
        end
      end
      WalkId: begin
        id_acc = {b, id_acc[SizeW-1:ByteW]};
        field_cnt++;
        if (field_cnt >= FieldBytes) begin
          field_cnt = '0;
          walk_st   = WalkSize;
        end
      end
      WalkSize: begin
        size_acc = {b, size_acc[SizeW-1:ByteW]};
        field_cnt++;
        if (field_cnt >= FieldBytes) begin
          field_cnt = '0;
          remaining = size_acc;
          if (id_acc == DataTag) begin
            data_len = size_acc;
            r.phase  = PhaseSize;
            walk_st  = (remaining == '0) ? WalkDone : WalkPayload;
          end else begin
            // an empty chunk has no body: the next byte opens the next ID
            walk_st = (remaining == '0) ? WalkId : WalkSkip;
          end
        end
      end
      WalkSkip: begin
        remaining--;
        if (remaining == '0) walk_st = WalkId;
      end
      WalkPayload: begin
        r.phase        = PhasePayload;
        r.payload_byte = b;
        remaining--;
        if (remaining == '0) begin
          r.last_payload = 1'b1;
          walk_st        = WalkDone;
        end
      end
      default: begin
        r.phase = PhaseAfter;
        walk_st = WalkDone;
      end
    endcase
    if (r.phase != PhaseSkip) r.data_size = data_len;
    return r;
  endfunction

  task automatic report_fault(input string msg);
    $display("[%0t] result mismatch: %s", $realtime, msg);
    faults_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_walk();
      forecast_q.delete();
      pending_o = 0;
    end else begin
      // a result word always belongs to a byte taken at an earlier edge
      if (out_ch.valid && out_ch.ready) begin
        if (forecast_q.size() == 0) begin
          report_fault("result word with nothing outstanding");
        end else begin
          want = forecast_q.pop_front();
          if (out_ch.phase !== want.phase)
            report_fault($sformatf("phase %0d, want %0d", out_ch.phase, want.phase));
          if (out_ch.data_size !== want.data_size)
            report_fault($sformatf("data_size %08h, want %08h",
                                   out_ch.data_size, want.data_size));
          if (out_ch.payload_byte !== want.payload_byte)
            report_fault($sformatf("payload_byte %02h, want %02h",
                                   out_ch.payload_byte, want.payload_byte));
          if (out_ch.last_payload !== want.last_payload)
            report_fault($sformatf("last_payload %0b, want %0b",
                                   out_ch.last_payload, want.last_payload));
        end
      end
      if (in_ch.valid && in_ch.ready)
        forecast_q = {forecast_q, walk_byte(in_ch.data_byte, in_ch.start_of_file)};
      pending_o = forecast_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the WAV data chunk locator
// Builds a byte stream of short RIFF files, some well formed and some cut
// short or restarted, feeds it with random gaps and back-pressure and leaves
// the checking to the walk checker.
// ----------------------------------------------------------------------------
module tb import wdcl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StreamLen     = 1700;
  localparam int unsigned HoldAt        = 300;
  localparam int unsigned QuietTail     = 200;
  localparam int unsigned LongHold      = 150;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 4;

  // chunk IDs packed little-endian, as on the wire
  localparam logic [SizeW-1:0] FmtTag  = 32'h2074_6d66;
  localparam logic [SizeW-1:0] ListTag = 32'h5453_494c;

  logic        clk_i;
  logic        rst_ni;
  int unsigned words_pending;
  int unsigned fault_count;
  int unsigned quiet_cycles;
  bit          gaps_on;
  bit          hold_req;

  logic [ByteW-1:0] stream_b[$];
  logic             stream_sof[$];

  wdcl_in_if  byte_ch ();
  wdcl_out_if result_ch ();

  wav_data_chunk_locator_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (result_ch)
  );

  wdcl_walk_checker walk_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (byte_ch),
    .out_ch    (result_ch),
    .pending_o (words_pending),
    .faults_o  (fault_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void put(input logic [ByteW-1:0] b, input logic sof);
    stream_b   = {stream_b, b};
    stream_sof = {stream_sof, sof};
  endfunction

  function automatic void put_word(input logic [SizeW-1:0] w);
    for (int k = 0; k < 4; k++) put(w[8*k +: 8], 1'b0);
  endfunction

  function automatic void put_body(input int unsigned n);
    repeat (n) put(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void put_header(input logic sof);
    put(8'($urandom_range(0, 255)), sof);
    put_body(HeaderBytes - 1);
  endfunction

  // One file: a few other chunks, then 'data'; now and then cut short so the
  // next start mark lands mid-chunk.
  function automatic void build_random_file();
    int unsigned      n_other;
    int unsigned      size;
    logic [SizeW-1:0] id;
    put_header($urandom_range(0, 15) != 0);
    n_other = $urandom_range(0, 3);
    repeat (n_other) begin
      case ($urandom_range(0, 3))
        0:       id = FmtTag;
        1:       id = ListTag;
        2:       id = DataTag ^ (32'd1 << $urandom_range(0, 31));
        default: id = $urandom;
      endcase
      put_word(id);
      if ($urandom_range(0, 19) == 0) begin
        // huge body, abandoned by the next start mark
        put_word($urandom | 32'h8000_0000);
        put_body($urandom_range(0, 5));
        return;
      end
      size = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      put_word(size);
      put_body(size);
    end
    size = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
    if ($urandom_range(0, 11) == 0) size = $urandom;
    put_word(DataTag);
    put_word(size);
    if (size > 24) begin
      put_body($urandom_range(1, 6));
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      put_body($urandom_range(0, size));
      return;
    end
    put_body(size);
    put_body($urandom_range(0, 4));
  endfunction

  task automatic send_word(input logic [ByteW-1:0] b, input logic sof);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.start_of_file <= sof;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= '0;
    byte_ch.start_of_file <= 1'b0;
    gaps_on  = 1'b1;
    hold_req = 1'b0;

    // no start mark yet, empty data chunk, then bytes after it
    put_header(1'b0);
    put_word(DataTag);
    put_word(32'd0);
    put_body(2);
    // empty other chunk, full-scale data size, payload extremes, then restart
    put_header(1'b1);
    put_word(FmtTag);
    put_word(32'd0);
    put_word(DataTag);
    put_word(32'hFFFF_FFFF);
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    while (stream_b.size() < StreamLen) build_random_file();

    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    for (int unsigned i = 0; i < stream_b.size(); i++) begin
      if (i == HoldAt) hold_req = 1'b1;
      if (i + QuietTail >= stream_b.size()) gaps_on = 1'b0;
      send_word(stream_b[i], stream_sof[i]);
    end
    byte_ch.valid <= 1'b0;

    while (words_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_taker
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        // hold off long enough for the block to back up into its input
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule
